/* src/tcrw_pkg.sv */
// Shared types and constants for the text console region writer.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package tcrw_pkg;
   localparam int STORE_DEPTH = 8192;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int MAX_COLS    = 128;
   localparam int COL_LIMIT   = (MAX_COLS < 128) ? MAX_COLS : 128;
   localparam int ROW_LIMIT   = 128;
   localparam logic [7:0] BLANK_CHAR = 8'h20;

   typedef enum logic [2:0] {
      REQ_PUT    = 3'd0,
      REQ_SET    = 3'd1,
      REQ_SCROLL = 3'd2,
      REQ_FILL   = 3'd3,
      REQ_READ   = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_REGION_X      = 3'd0,
      CSR_REGION_Y      = 3'd1,
      CSR_REGION_WIDTH  = 3'd2,
      CSR_REGION_HEIGHT = 3'd3,
      CSR_LINE_PITCH    = 3'd4,
      CSR_COLOR_ATTR    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_COPY,
      PH_BLANK_H,
      PH_BLANK_V,
      PH_FILL,
      PH_PUT
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_START,
      ST_CALC,
      ST_READ,
      ST_WRITE,
      ST_CURSOR,
      ST_CELL_RD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic      load_req;
      logic      load_scroll;
      logic      cursor_update;
      logic      clear_walk;
      logic      advance_walk;
      logic      calc_cell;
      logic      mem_rd_src;
      logic      mem_rd_cell;
      logic      mem_we;
      logic      load_rsp;
      phase_type phase;
   } ctl_cmd_type;

   typedef struct packed {
      logic [2:0] req_code;
      logic       walk_empty;
      logic       walk_last;
      logic       need_scroll;
      logic       rsp_free;
   } ctl_stat_type;
endpackage
`default_nettype wire

/* src/tcrw_controller.sv */
// Sequencer for the text console region writer: steps each request through its phases.
// Depends on tcrw_pkg; drives the datapath only through command and status structs.
`default_nettype none
module tcrw_controller
   import tcrw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire ctl_stat_type stat,
   output ctl_cmd_type       cmd
);
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   function automatic phase_type next_phase(input phase_type p);
      phase_type n;
      begin
         unique case (p)
            PH_COPY:    n = PH_BLANK_H;
            PH_BLANK_H: n = PH_BLANK_V;
            default:    n = PH_FILL;
         endcase
         return n;
      end
   endfunction

   // The last phase of a scroll or a fill finishes the request.
   function automatic logic phase_is_final(input phase_type p);
      return (p == PH_BLANK_V) || (p == PH_FILL);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_PUT;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (req_code_type'(stat.req_code))
               REQ_PUT: begin
                  phase_in = PH_PUT;
                  state_in = ST_CALC;
               end
               REQ_SET: state_in = ST_CURSOR;
               REQ_SCROLL: begin
                  phase_in = PH_COPY;
                  state_in = ST_START;
               end
               REQ_FILL: begin
                  phase_in = PH_FILL;
                  state_in = ST_START;
               end
               REQ_READ: state_in = ST_CELL_RD;
               default:  state_in = ST_FINISH;
            endcase
         end
         ST_START: begin
            if (stat.walk_empty) begin
               if (phase_is_final(phase_ff)) state_in = ST_FINISH;
               else phase_in = next_phase(phase_ff);
            end else begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = (phase_ff == PH_COPY) ? ST_READ : ST_WRITE;
         end
         ST_READ: state_in = ST_WRITE;
         ST_WRITE: begin
            if (phase_ff == PH_PUT) begin
               state_in = ST_CURSOR;
            end else if (stat.walk_last) begin
               if (phase_is_final(phase_ff)) begin
                  state_in = ST_FINISH;
               end else begin
                  phase_in = next_phase(phase_ff);
                  state_in = ST_START;
               end
            end else begin
               state_in = ST_CALC;
            end
         end
         ST_CURSOR: begin
            if (stat.need_scroll) begin
               phase_in = PH_COPY;
               state_in = ST_START;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_CELL_RD: state_in = ST_FINISH;
         ST_FINISH: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.phase = phase_ff;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE:     cmd.load_req = req_valid;
         ST_DISPATCH: cmd.load_scroll = (stat.req_code == REQ_SCROLL);
         ST_START:    cmd.clear_walk = 1'b1;
         ST_CALC:     cmd.calc_cell = 1'b1;
         ST_READ:     cmd.mem_rd_src = 1'b1;
         ST_WRITE: begin
            cmd.mem_we       = 1'b1;
            cmd.advance_walk = (phase_ff != PH_PUT) && !stat.walk_last;
         end
         ST_CURSOR:   cmd.cursor_update = 1'b1;
         ST_CELL_RD:  cmd.mem_rd_cell = 1'b1;
         ST_FINISH:   cmd.load_rsp = stat.rsp_free;
         default:     cmd.load_req = 1'b0;
      endcase
   end
endmodule
`default_nettype wire

/* src/tcrw_datapath.sv */
// Datapath of the text console region writer: registers, cursor, region walk,
// address arithmetic and the two character-cell stores. Depends on tcrw_pkg.
`default_nettype none
module tcrw_datapath
   import tcrw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [2:0]        csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic [2:0]        req_type,
   input  wire logic [7:0]        req_char_code,
   input  wire logic signed [7:0] req_pos_x,
   input  wire logic signed [7:0] req_pos_y,
   input  wire logic signed [7:0] req_shift_cols,
   input  wire logic signed [7:0] req_shift_rows,
   input  wire logic [ADDR_W-1:0] req_cell_addr,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output logic [6:0]             rsp_cursor_col_rel,
   output logic [6:0]             rsp_cursor_row_rel,
   output logic [7:0]             rsp_cursor_col_abs,
   output logic [7:0]             rsp_cursor_row_abs,
   output logic [7:0]             rsp_read_char,
   output logic [7:0]             rsp_read_color,
   input  wire ctl_cmd_type       cmd,
   output ctl_stat_type           stat
);
   logic [6:0] region_x_ff, region_y_ff;
   logic [7:0] region_width_ff, region_height_ff, line_pitch_ff, color_attr_ff;

   logic [2:0]        req_code_ff;
   logic [7:0]        char_ff;
   logic signed [7:0] pos_x_ff, pos_y_ff, shift_cols_ff, shift_rows_ff;
   logic [ADDR_W-1:0] cell_addr_ff;

   logic [6:0] cursor_col_ff, cursor_row_ff;
   logic signed [8:0] hz_ff, vt_ff;
   logic [7:0] ah_ff, av_ff;
   logic [7:0] walk_i_ff, walk_j_ff;
   logic [7:0] dst_row_ff, dst_col_ff, src_row_ff, src_col_ff;

   logic [7:0] text_mem [STORE_DEPTH];
   logic [7:0] attr_mem [STORE_DEPTH];
   logic [7:0] rd_char_ff, rd_attr_ff;

   logic       rsp_valid_ff;
   logic [6:0] out_col_ff, out_row_ff;
   logic [7:0] out_col_abs_ff, out_row_abs_ff, out_char_ff, out_color_ff;

   // Effective region size after clamping.
   logic [7:0] eff_w, eff_h;
   always_comb begin
      eff_w = region_width_ff;
      if (region_width_ff == 8'd0) eff_w = 8'd1;
      else if (region_width_ff > 8'(COL_LIMIT)) eff_w = 8'(COL_LIMIT);
      eff_h = region_height_ff;
      if (region_height_ff == 8'd0) eff_h = 8'd1;
      else if (region_height_ff > 8'(ROW_LIMIT)) eff_h = 8'(ROW_LIMIT);
   end

   logic signed [9:0] w_s, h_s;
   assign w_s = signed'({2'b00, eff_w});
   assign h_s = signed'({2'b00, eff_h});

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         region_x_ff      <= 7'd0;
         region_y_ff      <= 7'd0;
         region_width_ff  <= 8'd80;
         region_height_ff <= 8'd60;
         line_pitch_ff    <= 8'd80;
         color_attr_ff    <= 8'd116;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_REGION_X:      region_x_ff      <= csr_wdata[6:0];
            CSR_REGION_Y:      region_y_ff      <= csr_wdata[6:0];
            CSR_REGION_WIDTH:  region_width_ff  <= csr_wdata;
            CSR_REGION_HEIGHT: region_height_ff <= csr_wdata;
            CSR_LINE_PITCH:    line_pitch_ff    <= csr_wdata;
            CSR_COLOR_ATTR:    color_attr_ff    <= csr_wdata;
            default:           region_x_ff      <= region_x_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_code_ff   <= req_type;
         char_ff       <= req_char_code;
         pos_x_ff      <= req_pos_x;
         pos_y_ff      <= req_pos_y;
         shift_cols_ff <= req_shift_cols;
         shift_rows_ff <= req_shift_rows;
         cell_addr_ff  <= req_cell_addr;
      end
   end

   // Saturated scroll amounts for an explicit scroll request.
   logic signed [8:0] sat_hz, sat_vt, sc9, sr9, w9, h9;
   always_comb begin
      sc9 = signed'({shift_cols_ff[7], shift_cols_ff});
      sr9 = signed'({shift_rows_ff[7], shift_rows_ff});
      w9  = signed'({1'b0, eff_w});
      h9  = signed'({1'b0, eff_h});
      sat_hz = sc9;
      if (sc9 > w9) sat_hz = w9;
      else if (sc9 < -w9) sat_hz = -w9;
      sat_vt = sr9;
      if (sr9 > h9) sat_vt = h9;
      else if (sr9 < -h9) sat_vt = -h9;
   end

   // Cursor placement; a row below the region asks for an upward scroll.
   logic signed [9:0] x_req, y_req, x_fix, y_fix, y_step, vt_need;
   logic              need_scroll;
   always_comb begin
      if (req_code_ff == REQ_PUT) begin
         x_req = signed'({3'b000, cursor_col_ff}) + 10'sd1;
         y_req = signed'({3'b000, cursor_row_ff});
      end else begin
         x_req = 10'(pos_x_ff);
         y_req = 10'(pos_y_ff);
      end
      x_fix  = x_req;
      y_step = y_req;
      if (x_req < 0) begin
         x_fix = '0;
      end else if (x_req >= w_s) begin
         x_fix  = '0;
         y_step = y_req + 10'sd1;
      end
      y_fix       = y_step;
      need_scroll = 1'b0;
      vt_need     = y_step - h_s + 10'sd1;
      if (vt_need > h_s) vt_need = h_s;
      if (y_step < 0) begin
         y_fix = '0;
      end else if (y_step >= h_s) begin
         y_fix       = h_s - 10'sd1;
         need_scroll = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= 7'd0;
         cursor_row_ff <= 7'd0;
      end else if (cmd.cursor_update) begin
         cursor_col_ff <= x_fix[6:0];
         cursor_row_ff <= y_fix[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_scroll) begin
         hz_ff <= sat_hz;
         vt_ff <= sat_vt;
         ah_ff <= (sat_hz < 0) ? 8'(-sat_hz) : 8'(sat_hz);
         av_ff <= (sat_vt < 0) ? 8'(-sat_vt) : 8'(sat_vt);
      end else if (cmd.cursor_update) begin
         hz_ff <= '0;
         vt_ff <= vt_need[8:0];
         ah_ff <= 8'd0;
         av_ff <= vt_need[7:0];
      end
   end

   // Walk geometry of the current phase.
   logic [7:0]        walk_ni, walk_nj;
   logic signed [9:0] wr, wc, wi, wj, ah_s, av_s, hz_s, vt_s;
   always_comb begin
      wi   = signed'({2'b00, walk_i_ff});
      wj   = signed'({2'b00, walk_j_ff});
      ah_s = signed'({2'b00, ah_ff});
      av_s = signed'({2'b00, av_ff});
      hz_s = 10'(hz_ff);
      vt_s = 10'(vt_ff);
      walk_ni = eff_h;
      walk_nj = eff_w;
      wr = wi;
      wc = wj;
      unique case (cmd.phase)
         PH_COPY: begin
            walk_ni = eff_h - av_ff;
            walk_nj = eff_w - ah_ff;
            wr = (vt_ff < 0) ? (h_s - 10'sd1 - wi) : wi;
            wc = (hz_ff < 0) ? (w_s - 10'sd1 - wj) : wj;
         end
         PH_BLANK_H: begin
            walk_nj = ah_ff;
            wc = ((hz_ff > 0) ? (w_s - ah_s) : 10'sd0) + wj;
         end
         PH_BLANK_V: begin
            walk_ni = av_ff;
            wr = ((vt_ff > 0) ? (h_s - av_s) : 10'sd0) + wi;
         end
         PH_FILL: begin
            walk_ni = eff_h;
         end
         default: begin
            wr = signed'({3'b000, cursor_row_ff});
            wc = signed'({3'b000, cursor_col_ff});
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_walk) begin
         walk_i_ff <= 8'd0;
         walk_j_ff <= 8'd0;
      end else if (cmd.advance_walk) begin
         if (walk_j_ff == walk_nj - 8'd1) begin
            walk_j_ff <= 8'd0;
            walk_i_ff <= walk_i_ff + 8'd1;
         end else begin
            walk_j_ff <= walk_j_ff + 8'd1;
         end
      end
   end

   logic signed [9:0] ry_s, rx_s, d_row, d_col, s_row, s_col;
   always_comb begin
      ry_s  = signed'({3'b000, region_y_ff});
      rx_s  = signed'({3'b000, region_x_ff});
      d_row = ry_s + wr;
      d_col = rx_s + wc;
      s_row = d_row + vt_s;
      s_col = d_col + hz_s;
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_cell) begin
         dst_row_ff <= d_row[7:0];
         dst_col_ff <= d_col[7:0];
         src_row_ff <= s_row[7:0];
         src_col_ff <= s_col[7:0];
      end
   end

   // Store address: screen row times pitch plus column, wrapped to the store.
   logic [15:0] dst_prod, src_prod;
   logic [16:0] dst_sum, src_sum;
   logic [ADDR_W-1:0] dst_addr, src_addr, rd_addr;
   always_comb begin
      dst_prod = dst_row_ff * line_pitch_ff;
      src_prod = src_row_ff * line_pitch_ff;
      dst_sum  = {1'b0, dst_prod} + {9'd0, dst_col_ff};
      src_sum  = {1'b0, src_prod} + {9'd0, src_col_ff};
      dst_addr = dst_sum[ADDR_W-1:0];
      src_addr = src_sum[ADDR_W-1:0];
      rd_addr  = cmd.mem_rd_cell ? cell_addr_ff : src_addr;
   end

   logic [7:0] wr_char, wr_attr;
   always_comb begin
      unique case (cmd.phase)
         PH_COPY: begin
            wr_char = rd_char_ff;
            wr_attr = rd_attr_ff;
         end
         PH_BLANK_H, PH_BLANK_V: begin
            wr_char = BLANK_CHAR;
            wr_attr = color_attr_ff;
         end
         default: begin
            wr_char = char_ff;
            wr_attr = color_attr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         text_mem[dst_addr] <= wr_char;
         attr_mem[dst_addr] <= wr_attr;
      end
      if (cmd.mem_rd_src || cmd.mem_rd_cell) begin
         rd_char_ff <= text_mem[rd_addr];
         rd_attr_ff <= attr_mem[rd_addr];
      end
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_col_ff     <= cursor_col_ff;
         out_row_ff     <= cursor_row_ff;
         out_col_abs_ff <= {1'b0, region_x_ff} + {1'b0, cursor_col_ff};
         out_row_abs_ff <= {1'b0, region_y_ff} + {1'b0, cursor_row_ff};
         out_char_ff    <= (req_code_ff == REQ_READ) ? rd_char_ff : 8'd0;
         out_color_ff   <= (req_code_ff == REQ_READ) ? rd_attr_ff : 8'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cursor_col_rel = out_col_ff;
   assign rsp_cursor_row_rel = out_row_ff;
   assign rsp_cursor_col_abs = out_col_abs_ff;
   assign rsp_cursor_row_abs = out_row_abs_ff;
   assign rsp_read_char      = out_char_ff;
   assign rsp_read_color     = out_color_ff;

   always_comb begin
      stat.req_code    = req_code_ff;
      stat.walk_empty  = (walk_ni == 8'd0) || (walk_nj == 8'd0);
      stat.walk_last   = (walk_i_ff == walk_ni - 8'd1) && (walk_j_ff == walk_nj - 8'd1);
      stat.need_scroll = need_scroll;
      stat.rsp_free    = rsp_free;
   end
endmodule
`default_nettype wire

/* src/text_console_region_writer_unit.sv */
// Text console region writer: put, set cursor, scroll, fill and read cell.
// Put calculates and writes the cell, then updates the cursor; set cursor updates it;
// read cell reads the stores. A put or set past the last row then walks a scroll. The
// next word is taken once the result is loaded. Scroll copies the kept cells by a read and a
// write and blanks vacated columns and rows; fill writes each cell. One request at a time.
// Reset clears cursor and handshake, presets the config registers; stores are not cleared.
`default_nettype none
module text_console_region_writer_unit
   import tcrw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [7:0]        csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_type,
   input  wire logic [7:0]        req_char_code,
   input  wire logic signed [7:0] req_pos_x,
   input  wire logic signed [7:0] req_pos_y,
   input  wire logic signed [7:0] req_shift_cols,
   input  wire logic signed [7:0] req_shift_rows,
   input  wire logic [ADDR_W-1:0] req_cell_addr,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [6:0]             rsp_cursor_col_rel,
   output logic [6:0]             rsp_cursor_row_rel,
   output logic [7:0]             rsp_cursor_col_abs,
   output logic [7:0]             rsp_cursor_row_abs,
   output logic [7:0]             rsp_read_char,
   output logic [7:0]             rsp_read_color
);
   ctl_cmd_type  cmd;
   ctl_stat_type stat;

   assign csr_ready = 1'b1;

   tcrw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   tcrw_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_type),
      .req_char_code      (req_char_code),
      .req_pos_x          (req_pos_x),
      .req_pos_y          (req_pos_y),
      .req_shift_cols     (req_shift_cols),
      .req_shift_rows     (req_shift_rows),
      .req_cell_addr      (req_cell_addr),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_col_rel (rsp_cursor_col_rel),
      .rsp_cursor_row_rel (rsp_cursor_row_rel),
      .rsp_cursor_col_abs (rsp_cursor_col_abs),
      .rsp_cursor_row_abs (rsp_cursor_row_abs),
      .rsp_read_char      (rsp_read_char),
      .rsp_read_color     (rsp_read_color),
      .cmd                (cmd),
      .stat               (stat)
   );

   // A word taken in keeps the input side closed while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted while busy");

   // The stores are written only while a request is in hand.
   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> req_stall)
      else $error("store written while idle");

   // Loading a result always presents it on the next cycle.
   a_rsp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("result lost after load");
endmodule
`default_nettype wire
